### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the carousel slot tracker.
// ----------------------------------------------------------------------------
package cst_pkg;

  typedef enum logic [1:0] {
    MODE_ROTATE     = 2'd0,
    MODE_WRITE_HEAD = 2'd1,
    MODE_WRITE_SLOT = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_t;

  localparam logic [2:0] CODE_OPEN    = 3'd0;
  localparam logic [2:0] CODE_WAITING = 3'd1;
  localparam logic [2:0] CODE_CLOSED  = 3'd2;
  localparam logic [2:0] CODE_RED     = 3'd3;
  localparam logic [2:0] CODE_GREEN   = 3'd4;

  localparam logic [3:0] LIMIT_MAX    = 4'd8;
  localparam logic [3:0] LIMIT_RESET  = 4'd5;
  localparam int         OFFSET_SPAN  = 16;
  localparam logic signed [5:0] NO_OFFSET = 6'sd17;
  localparam logic [2:0] COUNT_MAX    = 3'd7;

  typedef struct packed {
    logic signed [5:0] lo;
    logic signed [5:0] hi;
  } window_t;

endpackage

### hdl/cst_req_if.sv
// ----------------------------------------------------------------------------
// cst_req_if
// Request channel of the carousel slot tracker.
// ----------------------------------------------------------------------------
interface cst_req_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic signed [5:0] rotate_amount;
  logic [2:0]        slot_number;
  logic [2:0]        holder_code;

  modport source (output valid, mode, rotate_amount, slot_number, holder_code,
                  input ready);
  modport sink   (input valid, mode, rotate_amount, slot_number, holder_code,
                  output ready);
endinterface

### hdl/cst_res_if.sv
// ----------------------------------------------------------------------------
// cst_res_if
// Result channel of the carousel slot tracker.
// ----------------------------------------------------------------------------
interface cst_res_if ();
  logic              valid;
  logic              ready;
  logic [2:0]        head_code;
  logic signed [5:0] free_offset;
  logic signed [5:0] red_offset;
  logic signed [5:0] green_offset;
  logic signed [5:0] filled_offset;
  logic [2:0]        red_count;
  logic [2:0]        green_count;
  logic              all_taken;
  logic              none_filled;
  logic signed [4:0] twist_position;
  logic              rotate_clamped;

  modport source (output valid, head_code, free_offset, red_offset, green_offset,
                  filled_offset, red_count, green_count, all_taken, none_filled,
                  twist_position, rotate_clamped,
                  input ready);
  modport sink   (input valid, head_code, free_offset, red_offset, green_offset,
                  filled_offset, red_count, green_count, all_taken, none_filled,
                  twist_position, rotate_clamped,
                  output ready);
endinterface

### hdl/cst_scan.sv
// ----------------------------------------------------------------------------
// cst_scan
// Nearest matching slot inside the twist window, anticlockwise side wins ties.
// ----------------------------------------------------------------------------
module cst_scan import cst_pkg::*; #(
  parameter int NUM_SLOTS = 5,
  parameter int IDX_W     = 3
) (
  input  logic [NUM_SLOTS-1:0] match,
  input  logic [IDX_W-1:0]     head,
  input  window_t              win,
  output logic signed [5:0]    offset
);

  localparam int SUM_W = IDX_W + 1;

  logic [OFFSET_SPAN:0] hit_pos;
  logic [OFFSET_SPAN:0] hit_neg;

  for (genvar k = 0; k <= OFFSET_SPAN; k++) begin : g_off
    localparam int POS_IM = k % NUM_SLOTS;
    localparam int NEG_IM = (NUM_SLOTS - POS_IM) % NUM_SLOTS;
    localparam logic signed [5:0] POS_I = 6'(k);
    localparam logic signed [5:0] NEG_I = 6'(-k);

    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] neg_sum;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] neg_idx;

    assign pos_sum = {1'b0, head} + SUM_W'(POS_IM);
    assign neg_sum = {1'b0, head} + SUM_W'(NEG_IM);
    assign pos_idx = (pos_sum >= SUM_W'(NUM_SLOTS)) ?
                     IDX_W'(pos_sum - SUM_W'(NUM_SLOTS)) : pos_sum[IDX_W-1:0];
    assign neg_idx = (neg_sum >= SUM_W'(NUM_SLOTS)) ?
                     IDX_W'(neg_sum - SUM_W'(NUM_SLOTS)) : neg_sum[IDX_W-1:0];

    assign hit_pos[k] = match[pos_idx] && (POS_I >= win.lo) && (POS_I <= win.hi);
    assign hit_neg[k] = match[neg_idx] && (NEG_I >= win.lo) && (NEG_I <= win.hi);
  end

  // closest distance wins, negative side overrides at equal distance
  always_comb begin
    offset = NO_OFFSET;
    for (int k = OFFSET_SPAN; k >= 0; k--) begin
      if (hit_pos[k]) begin
        offset = $signed(6'(k));
      end
      if (hit_neg[k]) begin
        offset = $signed(6'(-k));
      end
    end
  end

endmodule

### hdl/carousel_slot_tracker.sv
// ----------------------------------------------------------------------------
// carousel_slot_tracker
// Slot contents and twist position of a rotating carousel, with nearest-slot
// searches, counts and flags reported after every request.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (rotate, write head slot, write named slot, query)
//   with valid/ready; res returns exactly one result per request, in order.
//   cfg_we/cfg_wdata write the twist limit; write it only while idle.
// Pipeline and throughput:
//   a request sits in the input register, then the state update and every
//   search run combinationally into the result register, which raises
//   res.valid; one request per cycle sustained while res.ready holds. The
//   rate is set by the single state update per cycle between those registers.
// Reset:
//   all slots open, position and head at home, twist limit 5, both
//   registers empty.
// Stall:
//   a held result keeps its register; one more request waits in the input
//   register, after which req.ready drops until res.ready returns.
// ----------------------------------------------------------------------------
module carousel_slot_tracker import cst_pkg::*; #(
  parameter int NUM_SLOTS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  cst_req_if.sink    req,
  cst_res_if.source  res
);

  localparam int IDX_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int WRAP_STEPS = (int'(LIMIT_MAX) + NUM_SLOTS - 1) / NUM_SLOTS;
  localparam logic signed [6:0] N_S = 7'(NUM_SLOTS);

  function automatic logic [IDX_W-1:0] wrap(input logic signed [4:0] v);
    logic signed [6:0] r;
    r = 7'(v);
    for (int s = 0; s < WRAP_STEPS; s++) begin
      if (r < 0) r = r + N_S;
    end
    for (int s = 0; s < WRAP_STEPS; s++) begin
      if (r >= N_S) r = r - N_S;
    end
    return IDX_W'(r);
  endfunction

  // state
  logic [2:0]        slots [NUM_SLOTS];
  logic signed [4:0] position;
  logic [IDX_W-1:0]  head;
  logic [3:0]        turn_cap;

  // input register
  logic              q_valid;
  mode_t             q_mode;
  logic signed [5:0] q_amt;
  logic [2:0]        q_slot;
  logic [2:0]        q_code;

  // result register
  logic              r_valid;
  logic [2:0]        r_head_code;
  logic signed [5:0] r_free, r_red, r_green, r_filled;
  logic [2:0]        r_red_count, r_green_count;
  logic              r_all_taken, r_none_filled, r_clamped;
  logic signed [4:0] r_position;

  logic advance;
  assign advance   = q_valid && (!r_valid || res.ready);
  assign req.ready = !q_valid || advance;

  // datapath
  logic [3:0]        lim;
  logic signed [6:0] lim_s, sum;
  logic signed [4:0] np, position_next;
  logic              clamp;
  logic [IDX_W-1:0]  head_next, wr_idx;
  logic [2:0]        code_fix;
  logic              wr_en;
  logic [2:0]        slots_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] m_free, m_red, m_green, m_filled, m_open;
  logic [CNT_W-1:0]  red_cnt, green_cnt;
  logic [2:0]        red_count, green_count;
  window_t           win;
  logic signed [5:0] free_off, red_off, green_off, filled_off;

  always_comb begin
    lim      = (turn_cap > LIMIT_MAX) ? LIMIT_MAX : turn_cap;
    lim_s    = $signed({3'b000, lim});
    code_fix = (q_code > CODE_GREEN) ? CODE_CLOSED : q_code;
    sum      = 7'(position) + 7'(q_amt);
    clamp    = 1'b0;
    np       = 5'(sum);
    if (sum > lim_s) begin
      np    = 5'(lim_s);
      clamp = 1'b1;
    end else if (sum < -lim_s) begin
      np    = 5'(-lim_s);
      clamp = 1'b1;
    end

    position_next = position;
    head_next     = head;
    wr_en         = 1'b0;
    wr_idx        = head;
    case (q_mode)
      MODE_ROTATE: begin
        position_next = np;
        head_next     = wrap(np);
      end
      MODE_WRITE_HEAD: begin
        wr_en = 1'b1;
      end
      MODE_WRITE_SLOT: begin
        wr_en  = 1'b1;
        wr_idx = wrap($signed({2'b00, q_slot}));
      end
      default: begin
      end
    endcase

    red_cnt   = '0;
    green_cnt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slots_next[i] = (wr_en && wr_idx == IDX_W'(i)) ? code_fix : slots[i];
      m_open[i]   = slots_next[i] == CODE_OPEN;
      m_free[i]   = m_open[i] || slots_next[i] == CODE_WAITING;
      m_red[i]    = slots_next[i] == CODE_RED;
      m_green[i]  = slots_next[i] == CODE_GREEN;
      m_filled[i] = m_red[i] || m_green[i];
      red_cnt     = red_cnt + CNT_W'(m_red[i]);
      green_cnt   = green_cnt + CNT_W'(m_green[i]);
    end
    red_count   = (32'(red_cnt) > 32'(COUNT_MAX)) ? COUNT_MAX : 3'(red_cnt);
    green_count = (32'(green_cnt) > 32'(COUNT_MAX)) ? COUNT_MAX : 3'(green_cnt);

    win.lo = 6'(position_next) - 6'(lim_s);
    win.hi = 6'(lim_s) - 6'(position_next);
  end

  cst_scan #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_scan_free (
    .match(m_free), .head(head_next), .win(win), .offset(free_off)
  );
  cst_scan #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_scan_red (
    .match(m_red), .head(head_next), .win(win), .offset(red_off)
  );
  cst_scan #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_scan_green (
    .match(m_green), .head(head_next), .win(win), .offset(green_off)
  );
  cst_scan #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_scan_filled (
    .match(m_filled), .head(head_next), .win(win), .offset(filled_off)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid  <= 1'b0;
      r_valid  <= 1'b0;
      position <= '0;
      head     <= '0;
      turn_cap <= LIMIT_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots[i] <= CODE_OPEN;
      end
    end else begin
      if (cfg_we) begin
        turn_cap <= cfg_wdata;
      end
      if (req.valid && req.ready) begin
        q_valid <= 1'b1;
      end else if (advance) begin
        q_valid <= 1'b0;
      end
      if (advance) begin
        r_valid  <= 1'b1;
        position <= position_next;
        head     <= head_next;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slots[i] <= slots_next[i];
        end
      end else if (res.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_mode <= req.mode;
      q_amt  <= req.rotate_amount;
      q_slot <= req.slot_number;
      q_code <= req.holder_code;
    end
    if (advance) begin
      r_head_code   <= slots_next[head_next];
      r_free        <= free_off;
      r_red         <= red_off;
      r_green       <= green_off;
      r_filled      <= filled_off;
      r_red_count   <= red_count;
      r_green_count <= green_count;
      r_all_taken   <= ~|m_open;
      r_none_filled <= (red_count == 3'd0) && (green_count == 3'd0);
      r_position    <= position_next;
      r_clamped     <= (q_mode == MODE_ROTATE) && clamp;
    end
  end

  assign res.valid          = r_valid;
  assign res.head_code      = r_head_code;
  assign res.free_offset    = r_free;
  assign res.red_offset     = r_red;
  assign res.green_offset   = r_green;
  assign res.filled_offset  = r_filled;
  assign res.red_count      = r_red_count;
  assign res.green_count    = r_green_count;
  assign res.all_taken      = r_all_taken;
  assign res.none_filled    = r_none_filled;
  assign res.twist_position = r_position;
  assign res.rotate_clamped = r_clamped;

  // checks
  assert property (@(posedge clk) disable iff (rst)
    head == wrap(position))
  else $error("head index out of step with position");

  assert property (@(posedge clk) disable iff (rst)
    position <= 5'sd8 && position >= -5'sd8)
  else $error("position beyond the largest twist limit");

  assert property (@(posedge clk) disable iff (rst)
    advance |=> r_valid && res.twist_position == position)
  else $error("result position differs from committed position");

  assert property (@(posedge clk) disable iff (rst)
    r_valid && r_clamped |->
      (r_position == $signed({1'b0, lim}) || r_position == -$signed({1'b0, lim})))
  else $error("clamped rotation not at the twist limit");

endmodule

### tb/carousel_slot_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carousel_slot_tracker_test
// Self-checking bench for the carousel slot tracker: a behavioral copy of the
// slot store and twist position predicts every result, directed requests
// cover the clamping, wrapping and undefined-code cases, and random requests
// run under several twist limits with random idling and back-pressure.
// ----------------------------------------------------------------------------
module carousel_slot_tracker_test import cst_pkg::*; ();

  localparam int SLOT_COUNT  = 5;
  localparam int NO_MATCH    = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_MAX    = 14;

  typedef enum int {SEEK_FREE, SEEK_RED, SEEK_GREEN, SEEK_FILLED} seek_t;

  typedef struct {
    logic [2:0]        head_code;
    logic signed [5:0] free_offset;
    logic signed [5:0] red_offset;
    logic signed [5:0] green_offset;
    logic signed [5:0] filled_offset;
    logic [2:0]        red_count;
    logic [2:0]        green_count;
    logic              all_taken;
    logic              none_filled;
    logic signed [4:0] twist_position;
    logic              rotate_clamped;
  } carousel_view_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  cst_req_if req_ch ();
  cst_res_if res_ch ();

  carousel_slot_tracker #(.NUM_SLOTS(SLOT_COUNT)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  logic [2:0]     tracked_slots [SLOT_COUNT];
  int             tracked_pos;
  logic [3:0]     tracked_limit;
  carousel_view_t pending_views [$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             hold_cycles = 0;
  bit             send_idling = 1'b1;
  bit             recv_idling = 1'b1;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int wrap_slot(int v);
    int r;
    r = v % SLOT_COUNT;
    if (r < 0) r += SLOT_COUNT;
    return r;
  endfunction

  function automatic int window_limit();
    return (tracked_limit > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(tracked_limit);
  endfunction

  function automatic bit is_kind(logic [2:0] c, seek_t kind);
    case (kind)
      SEEK_FREE:  return c == CODE_OPEN || c == CODE_WAITING;
      SEEK_RED:   return c == CODE_RED;
      SEEK_GREEN: return c == CODE_GREEN;
      default:    return c == CODE_RED || c == CODE_GREEN;
    endcase
  endfunction

  // ties resolve to the anticlockwise side since the scan starts there
  function automatic logic signed [5:0] nearest_offset(seek_t kind);
    int lim;
    int best;
    lim = window_limit();
    best = NO_MATCH;
    for (int i = tracked_pos - lim; i <= lim - tracked_pos; i++) begin
      if ((i < 0 ? -i : i) < (best < 0 ? -best : best) &&
          is_kind(tracked_slots[wrap_slot(tracked_pos + i)], kind))
        best = i;
    end
    return (best == NO_MATCH) ? NO_OFFSET : 6'(best);
  endfunction

  function automatic carousel_view_t predict_view(mode_t op, logic signed [5:0] amount,
                                                  logic [2:0] slot, logic [2:0] code);
    carousel_view_t v;
    logic [2:0]     stored;
    int             lim;
    int             next_pos;
    bit             clamped;
    int             reds;
    int             greens;
    bit             any_open;
    stored = (code > CODE_GREEN) ? CODE_CLOSED : code;
    clamped = 1'b0;
    case (op)
      MODE_ROTATE: begin
        lim = window_limit();
        next_pos = tracked_pos + int'(amount);
        if (next_pos > lim) begin
          next_pos = lim;
          clamped = 1'b1;
        end
        if (next_pos < -lim) begin
          next_pos = -lim;
          clamped = 1'b1;
        end
        tracked_pos = next_pos;
      end
      MODE_WRITE_HEAD: tracked_slots[wrap_slot(tracked_pos)] = stored;
      MODE_WRITE_SLOT: tracked_slots[int'(slot) % SLOT_COUNT] = stored;
      default: ;
    endcase
    reds = 0;
    greens = 0;
    any_open = 1'b0;
    foreach (tracked_slots[k]) begin
      if (tracked_slots[k] == CODE_RED && reds < COUNT_MAX) reds++;
      if (tracked_slots[k] == CODE_GREEN && greens < COUNT_MAX) greens++;
      if (tracked_slots[k] == CODE_OPEN) any_open = 1'b1;
    end
    v.head_code      = tracked_slots[wrap_slot(tracked_pos)];
    v.free_offset    = nearest_offset(SEEK_FREE);
    v.red_offset     = nearest_offset(SEEK_RED);
    v.green_offset   = nearest_offset(SEEK_GREEN);
    v.filled_offset  = nearest_offset(SEEK_FILLED);
    v.red_count      = 3'(reds);
    v.green_count    = 3'(greens);
    v.all_taken      = !any_open;
    v.none_filled    = (reds == 0 && greens == 0);
    v.twist_position = 5'(tracked_pos);
    v.rotate_clamped = clamped;
    return v;
  endfunction

  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, IDLE_MAX);
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
             field, cycle_count, got, want);
    error_count++;
  endtask

  task automatic send_request(mode_t op, logic signed [5:0] amount, logic [2:0] slot,
                              logic [2:0] code);
    int gap;
    gap = draw_gap(send_idling);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= op;
    req_ch.rotate_amount <= amount;
    req_ch.slot_number   <= slot;
    req_ch.holder_code   <= code;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_views.push_back(predict_view(op, amount, slot, code));
  endtask

  task automatic send_random_request();
    mode_t             op;
    logic signed [5:0] amount;
    logic [2:0]        slot;
    logic [2:0]        code;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = MODE_ROTATE;
    else if (pick < 60) op = MODE_WRITE_HEAD;
    else if (pick < 85) op = MODE_WRITE_SLOT;
    else op = MODE_QUERY;
    pick = $urandom_range(0, 9);
    if (pick < 6) amount = 6'(int'($urandom_range(0, 6)) - 3);
    else if (pick < 9) amount = 6'(int'($urandom_range(0, 32)) - 16);
    else amount = 6'($urandom_range(0, 63));
    slot = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_request(op, amount, slot, code);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_views.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_turn_cap(logic [3:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracked_limit = value;
  endtask

  task automatic test_directed_ops();
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_WRITE_HEAD, 6'sd0, 3'd0, CODE_RED);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd4, CODE_GREEN);
    // out-of-range slot and undefined code
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd7, 3'd6);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd6, CODE_WAITING);
    send_request(MODE_ROTATE, 6'sd1, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sd16, 3'd7, 3'd7);
    send_request(MODE_ROTATE, 6'sb100000, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sd31, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, -6'sd3, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_WRITE_HEAD, 6'sd0, 3'd0, 3'd7);
    send_request(MODE_WRITE_HEAD, 6'sd0, 3'd0, CODE_GREEN);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd3, CODE_RED);
    send_request(MODE_QUERY, 6'sb011111, 3'd7, 3'd7);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd1, CODE_OPEN);
    send_request(MODE_ROTATE, -6'sd8, 3'd0, CODE_OPEN);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd0, CODE_CLOSED);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd2, CODE_CLOSED);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd3, 3'd5);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd4, CODE_CLOSED);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
  endtask

  // position left outside a shrunken window, zero limit and limits above the cap
  task automatic test_limit_edges();
    set_turn_cap(4'd8);
    send_request(MODE_ROTATE, 6'sd16, 3'd0, CODE_OPEN);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    set_turn_cap(4'd1);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_WRITE_HEAD, 6'sd0, 3'd0, CODE_RED);
    send_request(MODE_ROTATE, 6'sd0, 3'd0, CODE_OPEN);
    set_turn_cap(4'd0);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sd5, 3'd0, CODE_OPEN);
    send_request(MODE_WRITE_SLOT, 6'sd0, 3'd3, CODE_GREEN);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    set_turn_cap(4'd15);
    send_request(MODE_ROTATE, 6'sd20, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, -6'sd16, 3'd0, CODE_OPEN);
    send_request(MODE_QUERY, 6'sd0, 3'd0, CODE_OPEN);
    send_request(MODE_ROTATE, 6'sb100000, 3'd0, CODE_OPEN);
  endtask

  task automatic test_random_mix(logic [3:0] limit_value, int count);
    set_turn_cap(limit_value);
    repeat (count) send_random_request();
  endtask

  task automatic test_back_pressure();
    send_idling = 1'b0;
    hold_cycles = 40;
    repeat (40) send_random_request();
    hold_cycles = 120;
    repeat (40) send_random_request();
    send_idling = 1'b1;
  endtask

  task automatic test_full_rate();
    send_idling = 1'b0;
    recv_idling = 1'b0;
    repeat (150) send_random_request();
    send_idling = 1'b1;
    recv_idling = 1'b1;
  endtask

  initial begin : result_check
    carousel_view_t want;
    int             pause;
    res_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pause = hold_cycles;
        hold_cycles = 0;
      end else begin
        pause = draw_gap(recv_idling);
      end
      if (pause > 0) begin
        res_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (res_ch.valid !== 1'b1) @(posedge clk);
      if (pending_views.size() == 0) begin
        flag_mismatch("unrequested result", 1, 0);
      end else begin
        want = pending_views.pop_front();
        if (res_ch.head_code !== want.head_code)
          flag_mismatch("head_code", res_ch.head_code, want.head_code);
        if (res_ch.free_offset !== want.free_offset)
          flag_mismatch("free_offset", res_ch.free_offset, want.free_offset);
        if (res_ch.red_offset !== want.red_offset)
          flag_mismatch("red_offset", res_ch.red_offset, want.red_offset);
        if (res_ch.green_offset !== want.green_offset)
          flag_mismatch("green_offset", res_ch.green_offset, want.green_offset);
        if (res_ch.filled_offset !== want.filled_offset)
          flag_mismatch("filled_offset", res_ch.filled_offset, want.filled_offset);
        if (res_ch.red_count !== want.red_count)
          flag_mismatch("red_count", res_ch.red_count, want.red_count);
        if (res_ch.green_count !== want.green_count)
          flag_mismatch("green_count", res_ch.green_count, want.green_count);
        if (res_ch.all_taken !== want.all_taken)
          flag_mismatch("all_taken", res_ch.all_taken, want.all_taken);
        if (res_ch.none_filled !== want.none_filled)
          flag_mismatch("none_filled", res_ch.none_filled, want.none_filled);
        if (res_ch.twist_position !== want.twist_position)
          flag_mismatch("twist_position", res_ch.twist_position, want.twist_position);
        if (res_ch.rotate_clamped !== want.rotate_clamped)
          flag_mismatch("rotate_clamped", res_ch.rotate_clamped, want.rotate_clamped);
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 4'd0;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_QUERY;
    req_ch.rotate_amount <= 6'sd0;
    req_ch.slot_number   <= 3'd0;
    req_ch.holder_code   <= CODE_OPEN;
    foreach (tracked_slots[k]) tracked_slots[k] = CODE_OPEN;
    tracked_pos = 0;
    tracked_limit = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_limit_edges();
    test_random_mix(4'd1, 150);
    test_random_mix(4'd8, 150);
    test_random_mix(4'd0, 150);
    test_random_mix(4'd15, 150);
    test_random_mix(4'd3, 150);
    test_random_mix(4'd5, 150);
    test_back_pressure();
    test_random_mix(4'($urandom_range(0, 15)), 150);
    test_full_rate();
    test_random_mix(4'($urandom_range(0, 15)), 150);
    drain_results();

    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
